@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked at every clock edge outside of reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ sv/sfc_pkg.sv @@
// Types and constants of the servo status frame checker.
package sfc_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_BYTE   = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  localparam logic KIND_PARAM  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] HDR_BYTE = 8'hFF;
  localparam logic [8:0] FRAME_OVERHEAD = 9'd6;
  localparam logic [8:0] LEN_EXTRA = 9'd2;

  // Fixed positions of the frame fields, counted from the first header byte.
  localparam logic [8:0] POS_ID     = 9'd2;
  localparam logic [8:0] POS_LENGTH = 9'd3;
  localparam logic [8:0] POS_ERROR  = 9'd4;
  localparam logic [8:0] POS_PARAM0 = 9'd5;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] expected_params;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] param_byte;
    logic [7:0] param_index;
    logic [1:0] frame_status;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
  } result_t;

  // Step request from the pipeline into the frame core.
  typedef struct packed {
    logic  en;
    item_t item;
  } step_t;

  // Answer of the frame core for the item being stepped.
  typedef struct packed {
    logic    fire;
    result_t res;
  } answer_t;

endpackage

@@ sv/sfc_in_if.sv @@
// Input channel of the frame checker: one command or received byte per beat.
interface sfc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] expected_params;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output expected_params,
                  output rx_byte, input ready);
  modport sink (input valid, input operation, input expected_params,
                input rx_byte, output ready);
endinterface

@@ sv/sfc_out_if.sv @@
// Output channel of the frame checker: a parameter byte or a final status per beat.
interface sfc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] param_byte;
  logic [7:0] param_index;
  logic [1:0] frame_status;
  logic [7:0] servo_id;
  logic [7:0] servo_error;

  modport source (output valid, output kind, output param_byte, output param_index,
                  output frame_status, output servo_id, output servo_error,
                  input ready);
  modport sink (input valid, input kind, input param_byte, input param_index,
                input frame_status, input servo_id, input servo_error,
                output ready);
endinterface

@@ sv/sfc_frame_core.sv @@
// Frame state and per-byte decision logic of the status frame checker.
module sfc_frame_core (
  input  logic             clk,
  input  logic             rst,
  input  sfc_pkg::step_t   step,
  output sfc_pkg::answer_t answer
);

  logic       active, active_next;
  logic [8:0] byte_position, byte_position_next;
  logic [7:0] expected_count, expected_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic       header_good, header_good_next;
  logic       length_good, length_good_next;
  logic [7:0] held_id, held_id_next;
  logic [7:0] held_error, held_error_next;

  logic [8:0] last_position;
  logic [8:0] param_offset;
  logic [7:0] want_sum;

  assign last_position = {1'b0, expected_count} + sfc_pkg::FRAME_OVERHEAD - 9'd1;
  assign param_offset  = byte_position - sfc_pkg::POS_PARAM0;
  assign want_sum      = ~running_sum;

  always_comb begin
    active_next         = active;
    byte_position_next  = byte_position;
    expected_count_next = expected_count;
    running_sum_next    = running_sum;
    header_good_next    = header_good;
    length_good_next    = length_good;
    held_id_next        = held_id;
    held_error_next     = held_error;

    answer.fire             = 1'b0;
    answer.res.kind         = sfc_pkg::KIND_PARAM;
    answer.res.param_byte   = 8'd0;
    answer.res.param_index  = 8'd0;
    answer.res.frame_status = sfc_pkg::ST_OK;
    answer.res.servo_id     = held_id;
    answer.res.servo_error  = held_error;

    case (step.item.operation)
      sfc_pkg::OP_START: begin
        active_next         = 1'b1;
        byte_position_next  = 9'd0;
        expected_count_next = step.item.expected_params;
        running_sum_next    = 8'd0;
        header_good_next    = 1'b1;
        length_good_next    = 1'b1;
        held_id_next        = 8'd0;
        held_error_next     = 8'd0;
      end
      sfc_pkg::OP_EXPIRE: begin
        if (active) begin
          active_next             = 1'b0;
          answer.fire             = 1'b1;
          answer.res.kind         = sfc_pkg::KIND_STATUS;
          answer.res.frame_status = sfc_pkg::ST_TIMEOUT;
        end
      end
      sfc_pkg::OP_BYTE: begin
        if (active) begin
          byte_position_next = byte_position + 9'd1;
          if (byte_position < sfc_pkg::POS_ID) begin
            if (step.item.rx_byte != sfc_pkg::HDR_BYTE) begin
              header_good_next = 1'b0;
            end
          end else if (byte_position == last_position) begin
            active_next     = 1'b0;
            answer.fire     = 1'b1;
            answer.res.kind = sfc_pkg::KIND_STATUS;
            if (!header_good) begin
              answer.res.frame_status = sfc_pkg::ST_TIMEOUT;
            end else if (!length_good || want_sum != step.item.rx_byte) begin
              answer.res.frame_status = sfc_pkg::ST_CHECKSUM;
            end else begin
              answer.res.frame_status = sfc_pkg::ST_OK;
            end
          end else begin
            running_sum_next = running_sum + step.item.rx_byte;
            if (byte_position == sfc_pkg::POS_ID) begin
              held_id_next = step.item.rx_byte;
            end else if (byte_position == sfc_pkg::POS_LENGTH) begin
              length_good_next = ({1'b0, step.item.rx_byte} ==
                                  {1'b0, expected_count} + sfc_pkg::LEN_EXTRA);
            end else if (byte_position == sfc_pkg::POS_ERROR) begin
              held_error_next = step.item.rx_byte;
            end else begin
              answer.fire            = 1'b1;
              answer.res.kind        = sfc_pkg::KIND_PARAM;
              answer.res.param_byte  = step.item.rx_byte;
              answer.res.param_index = param_offset[7:0];
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (!step.en) begin
      answer.fire = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      byte_position  <= 9'd0;
      expected_count <= 8'd0;
      running_sum    <= 8'd0;
      header_good    <= 1'b1;
      length_good    <= 1'b1;
      held_id        <= 8'd0;
      held_error     <= 8'd0;
    end else if (step.en) begin
      active         <= active_next;
      byte_position  <= byte_position_next;
      expected_count <= expected_count_next;
      running_sum    <= running_sum_next;
      header_good    <= header_good_next;
      length_good    <= length_good_next;
      held_id        <= held_id_next;
      held_error     <= held_error_next;
    end
  end

endmodule

@@ sv/servo_status_frame_checker_unit.sv @@
// Top level of the servo status frame checker: input register, frame core, result register.
//
// Usage. The items channel carries one beat per command or received byte:
// operation 0 arms the checker with expected_params parameter bytes, operation 1
// delivers a received byte in rx_byte, and operation 2 reports that the read
// window has expired. The results channel carries a parameter byte (kind 0)
// for each parameter of the frame and one final status (kind 1) at the
// checksum byte or on expiry of an unfinished frame.
// Path: an accepted input beat is registered in the input register, and its result
// in the result register. Throughput: one input beat per cycle while results are
// taken; the core updates the frame state once for each stepped beat.
// Reset clears the pipeline and leaves the checker idle, so bytes and expiry
// beats are ignored until a start beat arrives.
// Stall: when the receiver holds ready low while a result waits, the result
// register and the input register both hold, and items.ready drops only once
// the input register is also full; no beat is lost or repeated.
`include "assert_macros.svh"

module servo_status_frame_checker_unit (
  input logic     clk,
  input logic     rst,
  sfc_in_if.sink  items,
  sfc_out_if.source results
);

  // Input register.
  logic            s1_valid;
  sfc_pkg::item_t  s1_item;

  // Result register.
  logic              res_valid;
  sfc_pkg::result_t  res_data;

  // The core steps whenever the result register can take its answer.
  logic              advance;
  sfc_pkg::step_t    step;
  sfc_pkg::answer_t  answer;

  assign advance     = !res_valid || results.ready;
  assign items.ready = !s1_valid || advance;

  assign step.en   = s1_valid && advance;
  assign step.item = s1_item;

  sfc_frame_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .answer (answer)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready) begin
      s1_item.operation       <= items.operation;
      s1_item.expected_params <= items.expected_params;
      s1_item.rx_byte         <= items.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= answer.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= answer.res;
    end
  end

  assign results.valid        = res_valid;
  assign results.kind         = res_data.kind;
  assign results.param_byte   = res_data.param_byte;
  assign results.param_index  = res_data.param_index;
  assign results.frame_status = res_data.frame_status;
  assign results.servo_id     = res_data.servo_id;
  assign results.servo_error  = res_data.servo_error;

  // An item waiting in the input register while the output is stalled stays put.
  `ASSERT_NEXT(a_s1_hold, s1_valid && !advance, s1_valid && $stable(s1_item))
  // A new result can only come from an item that sat in the input register.
  `ASSERT_IMPLIES(a_res_source, $rose(res_valid), $past(s1_valid))
  // Parameter beats never carry a frame status.
  `ASSERT_ALWAYS(a_param_status,
    !(res_valid && res_data.kind == sfc_pkg::KIND_PARAM) ||
    res_data.frame_status == sfc_pkg::ST_OK, "parameter beat with a status")

endmodule
